// ----- src/yasd_pkg.sv -----
// ----------------------------------------------------------------------------
// yasd_pkg
// Shared types and fixed constants of the yaw acceleration spike detector.
// ----------------------------------------------------------------------------
package yasd_pkg;

  // fixed field widths
  localparam int YAW_W    = 25;  // signed Q8.16 degrees
  localparam int FT_W     = 24;  // unsigned Q0.24 seconds
  localparam int SCORE_W  = 17;  // Q0.16, up to 1.0
  localparam int LIM_W    = 32;  // acceleration limits, Q.16
  localparam int CFG_W    = 32;  // config data width
  localparam int CFG_IDX_W = 3;
  localparam int FRAMES_W = 3;
  localparam int PROD_W   = 2 * SCORE_W;

  localparam int RATE_FRAC_BITS = 16;
  localparam int MAG1_W        = 26;  // magnitude of a wrapped yaw difference
  localparam int HALF_TURN_DEG = 180;
  localparam int FULL_TURN_DEG = 360;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 3'd4;
  localparam logic [SCORE_W-1:0]  Q16_ONE    = 17'd65536;
  localparam logic [15:0]         ROUND_HALF = 16'd32768;

  // register reset values
  localparam logic [LIM_W-1:0]   MATCH_LIMIT_RST  = 32'd65536;
  localparam logic [LIM_W-1:0]   LOW_LIMIT_RST    = 32'd131072;
  localparam logic [LIM_W-1:0]   SPIKE_MARGIN_RST = 32'd131072;
  localparam logic [SCORE_W-1:0] ALARM_LEVEL_RST  = 17'd58982;
  localparam logic [SCORE_W-1:0] SMOOTH_WEIGHT_RST = 17'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_LIMIT   = 3'd0,
    CFG_LOW_LIMIT     = 3'd1,
    CFG_SPIKE_MARGIN  = 3'd2,
    CFG_ALARM_LEVEL   = 3'd3,
    CFG_SMOOTH_WEIGHT = 3'd4
  } cfg_index_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_DIV1  = 8'b0000_0100,
    ST_AMAG  = 8'b0000_1000,
    ST_DIV2  = 8'b0001_0000,
    ST_EVAL  = 8'b0010_0000,
    ST_SPIKE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

endpackage

// ----- src/yasd_in_if.sv -----
// ----------------------------------------------------------------------------
// yasd_in_if
// Input channel: one word per tick with yaw angle and frame time.
// ----------------------------------------------------------------------------
interface yasd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [yasd_pkg::YAW_W-1:0]    yaw_angle;
  logic        [yasd_pkg::FT_W-1:0]     frame_time;

  modport source (output valid, output yaw_angle, output frame_time, input ready);
  modport sink   (input valid, input yaw_angle, input frame_time, output ready);
endinterface

// ----- src/yasd_out_if.sv -----
// ----------------------------------------------------------------------------
// yasd_out_if
// Output channel: one word per tick with detection flag and score.
// ----------------------------------------------------------------------------
interface yasd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             detected;
  logic [yasd_pkg::SCORE_W-1:0]     score;

  modport source (output valid, output detected, output score, input ready);
  modport sink   (input valid, input detected, input score, output ready);
endinterface

// ----- src/yasd_div.sv -----
// ----------------------------------------------------------------------------
// yasd_div
// Saturating restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module yasd_div #(
  parameter int RATE_W = 48,
  parameter int CNT_W  = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [RATE_W-1:0]            num,    // MSB first, zeros follow
  input  logic [CNT_W-1:0]             count,  // quotient bits to develop
  input  logic [yasd_pkg::FT_W-1:0]    den,
  output logic                         done,
  output logic [RATE_W-2:0]            quo     // saturated at all ones
);

  localparam int QW = RATE_W - 1;
  localparam int FW = yasd_pkg::FT_W;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RATE_W-1:0] nsh;
  logic [FW-1:0]     rem;
  logic [QW-1:0]     q;
  logic              sat;

  logic [FW:0]       rem_sh;
  logic [FW:0]       trial;
  logic              qb;
  logic              trivial;

  always_comb begin
    rem_sh  = {rem, nsh[RATE_W-1]};
    trial   = rem_sh - {1'b0, den};
    qb      = (rem_sh >= {1'b0, den});
    trivial = (num == '0) || (den == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= !trivial;
        done <= trivial;
        // zero divisor with nonzero dividend goes straight to the cap
        sat  <= (den == '0) && (num != '0);
        q    <= '0;
        rem  <= '0;
        nsh  <= num;
        cnt  <= count;
      end else if (busy) begin
        rem <= qb ? trial[FW-1:0] : rem_sh[FW-1:0];
        // top bit set means q*2+qb exceeds the cap
        sat <= sat | q[QW-1];
        q   <= {q[QW-2:0], qb};
        nsh <= {nsh[RATE_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quo = sat ? {QW{1'b1}} : q;

endmodule

// ----- src/yaw_accel_spike_detector_core.sv -----
// ----------------------------------------------------------------------------
// yaw_accel_spike_detector_core
// Yaw speed / acceleration spike detector with rolling score.
// ----------------------------------------------------------------------------
// Takes one word per game tick (yaw angle Q8.16 deg, frame time Q0.24 s) and
// returns one word (detected, score Q0.16) for each. The block works on one
// word at a time: in_ch.ready is high only while idle. Ready comes back once
// the word's result is taken into the output register. The single shared
// divider develops one quotient bit per cycle and runs twice per word (yaw
// speed, then yaw acceleration); a zero frame time or zero dividend skips
// the quotient steps of a division. The result sits in an output register,
// so the next word is accepted while the previous result still waits on
// out_ch.ready; only if that result is still unread when the next one is
// finished does the block wait in its last step.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module yaw_accel_spike_detector_core #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int TIME_FRAC_BITS  = 24,
  parameter int RATE_WIDTH      = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  yasd_in_if.sink                           in_ch,
  yasd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [yasd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [yasd_pkg::CFG_W-1:0]        cfg_data
);

  // signed width that holds a yaw difference and a full turn
  localparam int DW = (ANGLE_FRAC_BITS + 11 > 27) ? ANGLE_FRAC_BITS + 11 : 27;
  localparam int QW = RATE_WIDTH - 1;       // rate magnitude width
  localparam int CW = RATE_WIDTH + 1;       // common compare width
  localparam int SPEED_SHIFT = TIME_FRAC_BITS + yasd_pkg::RATE_FRAC_BITS
                               - ANGLE_FRAC_BITS;
  localparam int SPEED_STEPS = yasd_pkg::MAG1_W + SPEED_SHIFT;
  localparam int ACCEL_STEPS = RATE_WIDTH + TIME_FRAC_BITS;
  localparam int CNT_W = $clog2(ACCEL_STEPS + 1);
  localparam logic signed [DW-1:0] HALF_TURN =
    DW'(yasd_pkg::HALF_TURN_DEG) << ANGLE_FRAC_BITS;
  localparam logic signed [DW-1:0] FULL_TURN =
    DW'(yasd_pkg::FULL_TURN_DEG) << ANGLE_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [yasd_pkg::LIM_W-1:0]   match_limit;
  logic [yasd_pkg::LIM_W-1:0]   low_limit;
  logic [yasd_pkg::LIM_W-1:0]   spike_margin;
  logic [yasd_pkg::SCORE_W-1:0] alarm_level;
  logic [yasd_pkg::SCORE_W-1:0] smooth_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit   <= yasd_pkg::MATCH_LIMIT_RST;
      low_limit     <= yasd_pkg::LOW_LIMIT_RST;
      spike_margin  <= yasd_pkg::SPIKE_MARGIN_RST;
      alarm_level   <= yasd_pkg::ALARM_LEVEL_RST;
      smooth_weight <= yasd_pkg::SMOOTH_WEIGHT_RST;
    end else if (cfg_we) begin
      case (yasd_pkg::cfg_index_t'(cfg_index))
        yasd_pkg::CFG_MATCH_LIMIT:   match_limit   <= cfg_data;
        yasd_pkg::CFG_LOW_LIMIT:     low_limit     <= cfg_data;
        yasd_pkg::CFG_SPIKE_MARGIN:  spike_margin  <= cfg_data;
        yasd_pkg::CFG_ALARM_LEVEL:   alarm_level   <= cfg_data[yasd_pkg::SCORE_W-1:0];
        yasd_pkg::CFG_SMOOTH_WEIGHT: smooth_weight <= cfg_data[yasd_pkg::SCORE_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tracking state and working registers
  // --------------------------------------------------------------------------
  yasd_pkg::state_t state;

  logic signed [yasd_pkg::YAW_W-1:0] yaw_in;
  logic        [yasd_pkg::FT_W-1:0]  ft;
  logic signed [yasd_pkg::YAW_W-1:0] prev_yaw;
  logic                              diff_neg;
  logic                              speed_neg;   // sign of current speed
  logic [QW-1:0]                     speed_mag;
  logic                              prev_neg;
  logic [QW-1:0]                     prev_mag;
  logic [QW-1:0]                     acc_cur;
  logic [QW-1:0]                     acc_one;     // one tick back
  logic [QW-1:0]                     acc_two;     // two ticks back
  logic [yasd_pkg::FRAMES_W-1:0]     frames;
  logic [yasd_pkg::SCORE_W-1:0]      score;
  logic                              upd;         // score moves this tick
  logic                              spike;
  logic [RATE_WIDTH-1:0]             sum_r;       // outer sum (2x average)
  logic [RATE_WIDTH-1:0]             mid2_r;      // 2x middle accel
  logic [yasd_pkg::PROD_W-1:0]       prod;

  logic                              out_valid;
  logic                              out_det;
  logic [yasd_pkg::SCORE_W-1:0]      out_score;

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic                  div_start;
  logic [RATE_WIDTH-1:0] div_num;
  logic [CNT_W-1:0]      div_count;
  logic                  div_done;
  logic [QW-1:0]         div_quo;

  yasd_div #(
    .RATE_W (RATE_WIDTH),
    .CNT_W  (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .count (div_count),
    .den   (ft),
    .done  (div_done),
    .quo   (div_quo)
  );

  // --------------------------------------------------------------------------
  // Combinational datapath
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]           diff_raw;
  logic signed [DW-1:0]           diff_w;
  logic        [DW-1:0]           diff_abs;
  logic        [RATE_WIDTH-1:0]   acc_num;
  logic        [QW-1:0]           gap;
  logic                           gap_ok;
  logic                           spike_c;
  logic        [yasd_pkg::SCORE_W-1:0] wc;
  logic        [yasd_pkg::SCORE_W-1:0] one_minus_w;
  logic        [yasd_pkg::PROD_W:0]    score_sum;
  logic        [yasd_pkg::SCORE_W-1:0] score_new;
  logic        [yasd_pkg::SCORE_W-1:0] score_fin;
  logic                           out_free;

  always_comb begin
    // yaw difference wrapped once into +-180 deg
    diff_raw = DW'(yaw_in) - DW'(prev_yaw);
    diff_w   = diff_raw;
    if (diff_raw > HALF_TURN) begin
      diff_w = diff_raw - FULL_TURN;
    end
    if (diff_raw < -HALF_TURN) begin
      diff_w = diff_raw + FULL_TURN;
    end
    diff_abs = (diff_w < 0) ? DW'(-diff_w) : DW'(diff_w);

    // speed difference magnitude, signs handled separately
    if (speed_neg != prev_neg) begin
      acc_num = RATE_WIDTH'(speed_mag) + RATE_WIDTH'(prev_mag);
    end else if (speed_mag >= prev_mag) begin
      acc_num = RATE_WIDTH'(speed_mag - prev_mag);
    end else begin
      acc_num = RATE_WIDTH'(prev_mag - speed_mag);
    end

    gap    = (acc_cur >= acc_two) ? (acc_cur - acc_two) : (acc_two - acc_cur);
    gap_ok = CW'(gap) < CW'(match_limit);

    spike_c = (CW'(sum_r) < CW'({low_limit, 1'b0})) && (mid2_r > sum_r) &&
              (CW'(mid2_r - sum_r) > CW'({spike_margin, 1'b0}));

    wc          = (smooth_weight > yasd_pkg::Q16_ONE) ? yasd_pkg::Q16_ONE : smooth_weight;
    one_minus_w = yasd_pkg::Q16_ONE - wc;
    score_sum   = (yasd_pkg::PROD_W + 1)'(prod)
                + (spike ? (yasd_pkg::PROD_W + 1)'({wc, 16'd0})
                         : (yasd_pkg::PROD_W + 1)'(0))
                + (yasd_pkg::PROD_W + 1)'(yasd_pkg::ROUND_HALF);
    score_new   = score_sum[16 +: yasd_pkg::SCORE_W];
    score_fin   = upd ? score_new : score;

    out_free = !out_valid || out_ch.ready;

    div_start = (state == yasd_pkg::ST_PREP) || (state == yasd_pkg::ST_AMAG);
    if (state == yasd_pkg::ST_PREP) begin
      div_num   = {diff_abs[yasd_pkg::MAG1_W-1:0],
                   {(RATE_WIDTH - yasd_pkg::MAG1_W){1'b0}}};
      div_count = CNT_W'(SPEED_STEPS);
    end else begin
      div_num   = acc_num;
      div_count = CNT_W'(ACCEL_STEPS);
    end
  end

  // --------------------------------------------------------------------------
  // Output register valid: set when a word is finished, cleared when read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == yasd_pkg::ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= yasd_pkg::ST_IDLE;
      prev_yaw  <= '0;
      prev_neg  <= 1'b0;
      prev_mag  <= '0;
      acc_one   <= '0;
      acc_two   <= '0;
      frames    <= '0;
      score     <= '0;
    end else begin
      case (state)
        yasd_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            yaw_in <= in_ch.yaw_angle;
            ft     <= in_ch.frame_time;
            state  <= yasd_pkg::ST_PREP;
          end
        end

        yasd_pkg::ST_PREP: begin
          diff_neg <= (diff_w < 0);
          state    <= yasd_pkg::ST_DIV1;
        end

        yasd_pkg::ST_DIV1: begin
          if (div_done) begin
            // first tick has no speed; -0 counts as positive
            if (frames >= 3'd1) begin
              speed_mag <= div_quo;
              speed_neg <= diff_neg && (div_quo != '0);
            end else begin
              speed_mag <= '0;
              speed_neg <= 1'b0;
            end
            state <= yasd_pkg::ST_AMAG;
          end
        end

        yasd_pkg::ST_AMAG: begin
          state <= yasd_pkg::ST_DIV2;
        end

        yasd_pkg::ST_DIV2: begin
          if (div_done) begin
            acc_cur <= (frames >= 3'd2) ? div_quo : '0;
            state   <= yasd_pkg::ST_EVAL;
          end
        end

        yasd_pkg::ST_EVAL: begin
          upd    <= (frames >= 3'd3) && (speed_neg != prev_neg) && gap_ok;
          sum_r  <= RATE_WIDTH'(acc_cur) + RATE_WIDTH'(acc_two);
          mid2_r <= {acc_one, 1'b0};
          prod   <= yasd_pkg::PROD_W'(score) * yasd_pkg::PROD_W'(one_minus_w);
          state  <= yasd_pkg::ST_SPIKE;
        end

        yasd_pkg::ST_SPIKE: begin
          spike <= spike_c;
          state <= yasd_pkg::ST_FIN;
        end

        yasd_pkg::ST_FIN: begin
          if (out_free) begin
            score     <= score_fin;
            prev_yaw  <= yaw_in;
            prev_neg  <= speed_neg;
            prev_mag  <= speed_mag;
            acc_two   <= acc_one;
            acc_one   <= acc_cur;
            if (frames < yasd_pkg::FRAMES_MAX) begin
              frames <= frames + yasd_pkg::FRAMES_W'(1);
            end
            out_det   <= (score_fin > alarm_level);
            out_score <= score_fin;
            state     <= yasd_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= yasd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state == yasd_pkg::ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.detected = out_det;
  assign out_ch.score    = out_score;

endmodule

// ----- src/yasd_chk.sv -----
// ----------------------------------------------------------------------------
// yasd_chk
// Port-level checks of the detector core, bound into the core module.
// ----------------------------------------------------------------------------
module yasd_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           detected,
  input logic [yasd_pkg::SCORE_W-1:0]   score
);

  // score never leaves Q0.16 [0, 1.0]
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score <= yasd_pkg::Q16_ONE))
    else $error("score above 1.0");

  // a word keeps the block busy: no back-to-back accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // a new result only comes out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(score) && $stable(detected)))
    else $error("stalled result changed");

endmodule

bind yaw_accel_spike_detector_core yasd_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .detected  (out_ch.detected),
  .score     (out_ch.score)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the yaw acceleration spike detector core. Ticks are
// queued by a stimulus process and fed by a clocked driver. A clocked monitor
// scores every accepted tick with a bit-true model of its own. Each returned
// word is then checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

  // block parameters at their defaults
  localparam int ANG_FB = 16;
  localparam int TIME_FB = 24;
  localparam int RATE_W = 48;
  localparam int SPEED_SHIFT = TIME_FB + yasd_pkg::RATE_FRAC_BITS - ANG_FB;

  localparam longint HALF_TURN_Q = longint'(yasd_pkg::HALF_TURN_DEG) << ANG_FB;
  localparam longint FULL_TURN_Q = longint'(yasd_pkg::FULL_TURN_DEG) << ANG_FB;
  localparam logic [63:0] SCORE_ONE = 64'd65536;
  localparam logic [63:0] SCORE_HALF = 64'd32768;

  // covers every tick plus stalls; several times the slowest expected run
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 9;
  localparam int TICKS_PER_PHASE = 50;

  typedef struct {
    logic signed [yasd_pkg::YAW_W-1:0] yaw;
    logic [yasd_pkg::FT_W-1:0]         ft;
  } tick_t;

  typedef struct {
    logic                         detected;
    logic [yasd_pkg::SCORE_W-1:0] score;
  } score_word_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  yasd_pkg::cfg_index_t        cfg_index;
  logic [yasd_pkg::CFG_W-1:0]  cfg_data;

  yasd_in_if  in_if();
  yasd_out_if out_if();

  yaw_accel_spike_detector_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus side
  tick_t       tick_queue[$];
  tick_t       drv_tick;
  int          sent_count = 0;    // words put on in_if by the driver
  int          accept_count = 0;  // input handshakes seen by the monitor
  int          src_idle_pct;
  int          snk_idle_pct;
  int          gen_yaw;      // running yaw of the generated sequence

  // checking side
  score_word_t expected_scores[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // register mirror
  logic [yasd_pkg::LIM_W-1:0]   match_lim;
  logic [yasd_pkg::LIM_W-1:0]   low_lim;
  logic [yasd_pkg::LIM_W-1:0]   spike_marg;
  logic [yasd_pkg::SCORE_W-1:0] alarm_lvl;
  logic [yasd_pkg::SCORE_W-1:0] weight_q16;

  // model state
  logic signed [yasd_pkg::YAW_W-1:0] prev_yaw;
  longint                            prev_speed;
  logic [63:0]                       older_accel;   // magnitude two ticks back
  logic [63:0]                       middle_accel;  // magnitude one tick back
  int                                frames_seen;
  logic [yasd_pkg::SCORE_W-1:0]      roll_score;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // (num << shift) / den, truncated, one quotient bit per step; clamps at the
  // rate limit as soon as the partial quotient passes it. den == 0 clamps a nonzero num.
  function automatic logic [63:0] rate_quotient(input logic [63:0] num, input int shift,
                                                input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] qb;
    logic [63:0] cap;
    cap = (64'd1 << (RATE_W - 1)) - 64'd1;
    q = '0;
    r = '0;
    if (num == 0) return 64'd0;
    if (den == 0) return cap;
    for (int i = 0; i < 64 + shift; i++) begin
      logic nb;
      nb = 1'b0;
      if (i < 64) nb = num[63 - i];
      r = {r[62:0], nb};
      qb = (r >= den) ? 64'd1 : 64'd0;
      if (qb != 0) r = r - den;
      if (q * 2 + qb > cap) return cap;
      q = q * 2 + qb;
    end
    return q;
  endfunction

  function automatic longint signed_rate(input bit neg, input logic [63:0] mag,
                                         input int shift, input logic [63:0] den);
    logic [63:0] q;
    q = rate_quotient(mag, shift, den);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Advance the model by one tick and give the word the block should return.
  task automatic score_tick(input tick_t t, output score_word_t w);
    longint      yaw_v;
    longint      diff;
    longint      speed;
    longint      accel;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mag;
    logic [63:0] amag;
    logic [63:0] gap;
    logic [63:0] sum;
    logic [63:0] mid2;
    logic [63:0] wt;
    logic [63:0] nxt;
    bit          neg;
    bit          sa;
    bit          sb;
    bit          spike;
    yaw_v = longint'(t.yaw);
    speed = 0;
    accel = 0;

    // yaw speed: wrap the difference once into +-180 degrees
    if (frames_seen >= 1) begin
      diff = yaw_v - longint'(prev_yaw);
      if (diff > HALF_TURN_Q) diff = diff - FULL_TURN_Q;
      if (diff < -HALF_TURN_Q) diff = diff + FULL_TURN_Q;
      neg = diff < 0;
      speed = signed_rate(neg, neg ? 64'(-diff) : 64'(diff), SPEED_SHIFT, 64'(t.ft));
    end

    // yaw acceleration from sign/magnitude speeds
    if (frames_seen >= 2) begin
      a = (speed < 0) ? 64'(-speed) : 64'(speed);
      b = (prev_speed < 0) ? 64'(-prev_speed) : 64'(prev_speed);
      sa = speed < 0;
      sb = prev_speed < 0;
      if (sa != sb) begin
        mag = a + b;
        neg = sa;
      end else if (a >= b) begin
        mag = a - b;
        neg = sa;
      end else begin
        mag = b - a;
        neg = !sa;
      end
      accel = signed_rate(neg, mag, TIME_FB, 64'(t.ft));
    end
    amag = (accel < 0) ? 64'(-accel) : 64'(accel);

    // score moves only on a speed sign flip with matching outer accelerations
    if (frames_seen >= 3) begin
      gap = (amag >= older_accel) ? amag - older_accel : older_accel - amag;
      if (gap < 64'(match_lim) && ((speed < 0) != (prev_speed < 0))) begin
        sum = amag + older_accel;
        mid2 = middle_accel * 2;
        spike = (sum < 64'(low_lim) * 2) && (mid2 > sum) && (mid2 - sum > 64'(spike_marg) * 2);
        wt = (64'(weight_q16) > SCORE_ONE) ? SCORE_ONE : 64'(weight_q16);
        nxt = (64'(roll_score) * (SCORE_ONE - wt) + (spike ? SCORE_ONE * wt : 64'd0)
               + SCORE_HALF) >> 16;
        roll_score = nxt[yasd_pkg::SCORE_W-1:0];
      end
    end

    prev_yaw = t.yaw;
    prev_speed = speed;
    older_accel = middle_accel;
    middle_accel = amag;
    if (frames_seen < int'(yasd_pkg::FRAMES_MAX)) frames_seen++;

    w.detected = roll_score > alarm_lvl;
    w.score = roll_score;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one word at a time from tick_queue; valid holds until accepted.
  // Inputs move on the falling edge only.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.yaw_angle <= '0;
      in_if.frame_time <= '0;
    end else begin
      if (sent_count == accept_count && tick_queue.size() != 0 &&
          $urandom_range(99) >= src_idle_pct) begin
        drv_tick = tick_queue.pop_front();
        sent_count++;
      end
      in_if.valid <= (sent_count != accept_count);
      in_if.yaw_angle <= drv_tick.yaw;
      in_if.frame_time <= drv_tick.ft;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_if.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: output handshake is checked before the input handshake of the
  // same edge is scored, so a same-edge pair can never be mixed up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    score_word_t got;
    score_word_t want;
    tick_t       seen;
    if (rst) begin
      prev_yaw = '0;
      prev_speed = 0;
      older_accel = '0;
      middle_accel = '0;
      frames_seen = 0;
      roll_score = '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.detected = out_if.detected;
        got.score = out_if.score;
        if (expected_scores.size() == 0) begin
          flag_mismatch($sformatf("word with nothing pending: det=%0b score=%0d",
                                  got.detected, got.score));
        end else begin
          want = expected_scores.pop_front();
          if (got.detected !== want.detected)
            flag_mismatch($sformatf("detected %0b, want %0b", got.detected, want.detected));
          if (got.score !== want.score)
            flag_mismatch($sformatf("score %0d, want %0d", got.score, want.score));
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen.yaw = in_if.yaw_angle;
        seen.ft = in_if.frame_time;
        score_tick(seen, want);
        expected_scores = {expected_scores, want};
        accept_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_tick(input int yaw, input logic [yasd_pkg::FT_W-1:0] ft);
    tick_t t;
    t.yaw = yaw[yasd_pkg::YAW_W-1:0];
    t.ft = ft;
    tick_queue = {tick_queue, t};
    gen_yaw = int'(t.yaw);
  endtask

  // move the running yaw by d, kept inside the field by one turn
  task automatic yaw_step(input int d, input logic [yasd_pkg::FT_W-1:0] ft);
    int y;
    y = gen_yaw + d;
    if (y > int'(HALF_TURN_Q)) y = y - int'(FULL_TURN_Q);
    if (y < -int'(HALF_TURN_Q)) y = y + int'(FULL_TURN_Q);
    add_tick(y, ft);
  endtask

  // Mostly wobble bursts: two ticks of steady turn, then a small swing back
  // and a small swing forward, which flips the speed sign with matching
  // outer accelerations. The rest is raw noise over the whole fields.
  task automatic fill_random(input int count);
    int n;
    int reps;
    int b;
    int sgn;
    int e1;
    int e2;
    int f;
    logic [yasd_pkg::FT_W-1:0] ft_j;
    n = 0;
    while (n < count) begin
      if ($urandom_range(4) != 0) begin
        if ($urandom_range(3) == 0) f = $urandom_range(1 << 22, 1 << 16);
        else f = $urandom_range(24'hFFFFFF, 1 << 22);
        b = $urandom_range(30 << 16, 1);
        sgn = $urandom_range(1) ? 1 : -1;
        reps = $urandom_range(4, 1);
        for (int r = 0; r < reps; r++) begin
          e1 = $urandom_range(2000);
          e2 = $urandom_range(2000, 1);
          if ($urandom_range(7) == 0) e1 = $urandom_range(1 << 20);
          if ($urandom_range(7) == 0) e2 = 0;
          ft_j = f[yasd_pkg::FT_W-1:0];
          if ($urandom_range(15) == 0) ft_j = ft_j ^ yasd_pkg::FT_W'($urandom_range(255));
          yaw_step(-sgn * b, ft_j);
          yaw_step(-sgn * b, ft_j);
          yaw_step(sgn * e1, ft_j);
          yaw_step(-sgn * e2, ft_j);
          n += 4;
        end
      end else begin
        add_tick(int'($urandom), ($urandom_range(5) == 0) ? '0 : yasd_pkg::FT_W'($urandom));
        n++;
      end
    end
  endtask

  task automatic write_reg(input yasd_pkg::cfg_index_t idx,
                           input logic [yasd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      yasd_pkg::CFG_MATCH_LIMIT:   match_lim = val;
      yasd_pkg::CFG_LOW_LIMIT:     low_lim = val;
      yasd_pkg::CFG_SPIKE_MARGIN:  spike_marg = val;
      yasd_pkg::CFG_ALARM_LEVEL:   alarm_lvl = val[yasd_pkg::SCORE_W-1:0];
      yasd_pkg::CFG_SMOOTH_WEIGHT: weight_q16 = val[yasd_pkg::SCORE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] match, input logic [31:0] low,
                              input logic [31:0] margin, input logic [31:0] alarm,
                              input logic [31:0] weight);
    write_reg(yasd_pkg::CFG_MATCH_LIMIT, match);
    write_reg(yasd_pkg::CFG_LOW_LIMIT, low);
    write_reg(yasd_pkg::CFG_SPIKE_MARGIN, margin);
    write_reg(yasd_pkg::CFG_ALARM_LEVEL, alarm);
    write_reg(yasd_pkg::CFG_SMOOTH_WEIGHT, weight);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // every queued tick accepted and every predicted word returned, then a
  // settle wait for the block to go back to idle
  task automatic wait_drained(input int settle);
    while (tick_queue.size() != 0 || sent_count != accept_count ||
           expected_scores.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = yasd_pkg::CFG_MATCH_LIMIT;
    cfg_data = '0;
    gen_yaw = 0;
    match_lim = yasd_pkg::MATCH_LIMIT_RST;
    low_lim = yasd_pkg::LOW_LIMIT_RST;
    spike_marg = yasd_pkg::SPIKE_MARGIN_RST;
    alarm_lvl = yasd_pkg::ALARM_LEVEL_RST;
    weight_q16 = yasd_pkg::SMOOTH_WEIGHT_RST;
    src_idle_pct = 33;
    snk_idle_pct = 88;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    add_tick(0, 24'hFFFFFF);                 // first tick, speed forced to zero
    add_tick(11796480, 24'hFFFFFF);          // exactly +180 deg, no wrap
    add_tick(-11796480, 24'd1);              // -360 deg wraps to zero dividend
    add_tick(16777215, 24'd0);               // top of field, zero frame time
    add_tick(-16777216, 24'd0);              // one wrap step only, negative clamp
    add_tick(-16777216, 24'd0);              // zero dividend with zero frame time
    add_tick(-16777216, 24'hFFFFFF);         // speed back to zero from the clamp
    add_tick(0, 24'd1);                      // tiny frame time, large speed
    // steady turn, then +1/-1 raw swing: a spike at the default limits
    for (int r = 0; r < 3; r++) begin
      yaw_step(-655360, 24'hFFFFFF);
      yaw_step(-655360, 24'hFFFFFF);
      yaw_step(1, 24'hFFFFFF);
      yaw_step(-1, 24'hFFFFFF);
    end
    yaw_step(0, 24'd0);
    wait_drained(8);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_regs(32'd65536, 32'd131072, 32'd131072, 32'd32768, 32'd16384);
        1: program_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd65536);
        2: program_regs(32'd0, 32'd0, 32'hFFFFFFFF, 32'd65536, 32'd0);
        3: program_regs($urandom_range(1 << 24, 1 << 16), $urandom_range(1 << 30, 1 << 16),
                        $urandom_range(1 << 20), 32'd131071, 32'd131071);
        4: program_regs(32'hFFFFFFFF, 32'd1 << 20, 32'd0, 32'd65536, 32'd65536);
        5: program_regs(32'd1, 32'd1, 32'd0, 32'd1, 32'd1);
        default: program_regs($urandom_range(1 << 28, 1 << 16), $urandom_range(1 << 31, 1 << 16),
                              $urandom_range(1 << 22), $urandom_range(65536),
                              $urandom_range(65536));
      endcase
      // idle pattern: sender-light / receiver-heavy, then swapped, then none
      case (p / 3)
        0: begin
          src_idle_pct = 33;
          snk_idle_pct = 88;
        end
        1: begin
          src_idle_pct = 88;
          snk_idle_pct = 33;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      fill_random(TICKS_PER_PHASE);
      wait_drained(8);
    end

    repeat (20) @(posedge clk);
    if (expected_scores.size() != 0)
      flag_mismatch($sformatf("%0d predicted words never returned", expected_scores.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
